// ===== rtl/dual_order_service_queue_unit_defines.svh =====
// Assertion macros for the dual order service queue checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef DUAL_ORDER_SERVICE_QUEUE_UNIT_DEFINES_SVH
`define DUAL_ORDER_SERVICE_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DOSQ_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define DOSQ_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/dosq_pkg.sv =====
// Shared codes and controller/datapath interface types for the service queue.
// No dependencies.
package dosq_pkg;

	localparam logic [1:0] ACT_ARRIVE  = 2'd0;
	localparam logic [1:0] ACT_OLDEST  = 2'd1;
	localparam logic [1:0] ACT_HIGHEST = 2'd2;

	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_SERVED   = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam int NUM_WIDTH = 32;

	typedef struct packed {
		logic clr_step;    // clear one valid mark
		logic arrive;      // store arrival at tail
		logic set_full;
		logic set_empty;
		logic scan_start;  // start slot scan from head
		logic scan_oldest; // scan only the head slot
		logic scan_issue;  // issue one scan read
		logic inval;       // drop picked entry, take its number
		logic skip_rd;     // read valid mark at head
		logic skip_adv;    // step head past a hole
		logic load_out;    // move result to output register
	} dosq_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic full;
		logic empty;
		logic scan_last;
		logic pick_is_head;
		logic head_valid;
		logic out_free;
	} dosq_stat_t;

endpackage

// ===== rtl/dosq_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module dosq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/dosq_ctrl.sv =====
// Controller state machine for the service queue.
// Depends on dosq_pkg; drives dosq_datapath through command and status structs.
module dosq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [1:0]          action,
	input  dosq_pkg::dosq_stat_t st,
	output dosq_pkg::dosq_cmd_t  cmd
);
	import dosq_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_INVAL,
		S_SKIP_RD,
		S_SKIP_CHK,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_RESP;
					unique case (action)
						ACT_ARRIVE: begin
							if (st.full) begin
								cmd.set_full = 1'b1;
							end else begin
								cmd.arrive = 1'b1;
							end
						end
						ACT_OLDEST, ACT_HIGHEST: begin
							if (st.empty) begin
								cmd.set_empty = 1'b1;
							end else begin
								cmd.scan_start  = 1'b1;
								cmd.scan_oldest = (action == ACT_OLDEST);
								state_d         = S_SCAN;
							end
						end
						default: cmd.set_empty = 1'b1;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (st.scan_last) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: state_d = S_INVAL;
			S_INVAL: begin
				cmd.inval = 1'b1;
				// if the pick is the head, head moves past the removed slot here; more holes may follow
				state_d = st.pick_is_head ? S_SKIP_RD : S_RESP;
			end
			S_SKIP_RD: begin
				if (st.empty) begin
					state_d = S_RESP;
				end else begin
					cmd.skip_rd = 1'b1;
					state_d     = S_SKIP_CHK;
				end
			end
			S_SKIP_CHK: begin
				if (st.head_valid) begin
					state_d = S_RESP;
				end else begin
					cmd.skip_adv = 1'b1;
					state_d      = S_SKIP_RD;
				end
			end
			S_RESP: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/dosq_datapath.sv =====
// Datapath of the service queue: ring pointers, slot RAMs, max scan, result regs.
// Depends on dosq_pkg and dosq_ram; commanded by dosq_ctrl.
module dosq_datapath #(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dosq_pkg::dosq_cmd_t  cmd,
	output dosq_pkg::dosq_stat_t st,
	input  logic [31:0]          value,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [1:0]           status,
	output logic [31:0]          served_number
);
	import dosq_pkg::*;

	localparam int SW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = VALUE_WIDTH + NUM_WIDTH;

	function automatic logic [SW-1:0] slot_after(input logic [SW-1:0] s);
		return (s == SW'(DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	logic [SW-1:0]          head_q, tail_q, clr_q, scan_slot_q, pick_q, rd_slot_s1;
	logic [CW-1:0]          span_q, scan_cnt_q;
	logic [NUM_WIDTH-1:0]   next_q, best_number_q, res_number_q, out_number_q;
	logic [VALUE_WIDTH-1:0] best_q;
	logic [1:0]             res_status_q, out_status_q;
	logic                   found_q, rd_en_s1, out_valid_q;

	logic [VALUE_WIDTH+31:0] val_ext;
	logic [VALUE_WIDTH-1:0]  val_in;
	logic [DW-1:0]           data_rd;
	logic [VALUE_WIDTH-1:0]  rd_val;
	logic [NUM_WIDTH-1:0]    rd_num;
	logic                    vld_rd, vld_we, take;
	logic [SW-1:0]           vld_waddr, vld_raddr;

	// value kept to VALUE_WIDTH bits: truncated when wider than the field, zero-extended when narrower
	assign val_ext = {{VALUE_WIDTH{1'b0}}, value};
	assign val_in  = val_ext[VALUE_WIDTH-1:0];

	assign rd_val = data_rd[VALUE_WIDTH-1:0];
	assign rd_num = data_rd[DW-1:VALUE_WIDTH];

	assign vld_we = cmd.clr_step | cmd.arrive | cmd.inval;
	always_comb begin
		priority if (cmd.clr_step) begin
			vld_waddr = clr_q;
		end else if (cmd.arrive) begin
			vld_waddr = tail_q;
		end else begin
			vld_waddr = pick_q;
		end
	end
	assign vld_raddr = cmd.skip_rd ? head_q : scan_slot_q;

	dosq_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_data_ram (
		.clk   (clk),
		.we    (cmd.arrive),
		.waddr (tail_q),
		.wdata ({next_q, val_in}),
		.raddr (scan_slot_q),
		.rdata (data_rd)
	);

	dosq_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_valid_ram (
		.clk   (clk),
		.we    (vld_we),
		.waddr (vld_waddr),
		.wdata (cmd.arrive),
		.raddr (vld_raddr),
		.rdata (vld_rd)
	);

	// first valid slot wins on equal values
	assign take = rd_en_s1 && vld_rd && (!found_q || (rd_val > best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			span_q      <= '0;
			next_q      <= NUM_WIDTH'(1);
			clr_q       <= '0;
			scan_cnt_q  <= '0;
			rd_en_s1    <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.scan_issue;
			if (cmd.clr_step) begin
				clr_q <= slot_after(clr_q);
			end
			if (cmd.arrive) begin
				tail_q <= slot_after(tail_q);
				span_q <= span_q + 1'b1;
				next_q <= next_q + 1'b1;
			end
			if (cmd.scan_start) begin
				scan_cnt_q <= cmd.scan_oldest ? CW'(1) : span_q;
				found_q    <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
			if (cmd.scan_issue) begin
				scan_cnt_q <= scan_cnt_q - 1'b1;
			end
			if ((cmd.inval && (pick_q == head_q)) || cmd.skip_adv) begin
				head_q <= slot_after(head_q);
				span_q <= span_q - 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			scan_slot_q <= head_q;
		end else if (cmd.scan_issue) begin
			scan_slot_q <= slot_after(scan_slot_q);
		end
		rd_slot_s1 <= scan_slot_q;
		if (take) begin
			best_q        <= rd_val;
			best_number_q <= rd_num;
			pick_q        <= rd_slot_s1;
		end
		priority if (cmd.arrive) begin
			res_status_q <= ST_ACCEPTED;
			res_number_q <= next_q;
		end else if (cmd.set_full) begin
			res_status_q <= ST_FULL;
			res_number_q <= '0;
		end else if (cmd.set_empty) begin
			res_status_q <= ST_EMPTY;
			res_number_q <= '0;
		end else if (cmd.inval) begin
			res_status_q <= ST_SERVED;
			res_number_q <= best_number_q;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_number_q <= res_number_q;
		end
	end

	assign st.clr_last     = (clr_q == SW'(DEPTH - 1));
	assign st.full         = (span_q == CW'(DEPTH));
	assign st.empty        = (span_q == '0);
	assign st.scan_last    = (scan_cnt_q == CW'(1));
	assign st.pick_is_head = (pick_q == head_q);
	assign st.head_valid   = vld_rd;
	assign st.out_free     = !out_valid_q || m_tready;

	assign m_tvalid      = out_valid_q;
	assign status        = out_status_q;
	assign served_number = out_number_q;

endmodule

// ===== rtl/dual_order_service_queue_unit.sv =====
// Waiting store served oldest-first or highest-value-first; one request at a time.
// Arrival or empty/full answer: the result register is loaded on the accepting edge, then moved to the output register.
// Serve: scans the ring span from the head (serve-oldest reads only the head slot), then
// drops the pick; if the pick was the head, the head then steps past any holes behind it.
// After reset a clearing pass over all DEPTH slots resets the valid marks; no request is
// taken until it ends. Depends on dosq_pkg, dosq_ctrl, dosq_datapath, dosq_ram.
module dual_order_service_queue_unit #(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic [1:0]  s_tuser,  // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] served_number
	output logic [1:0]  m_tuser   // [1:0] status
);
	import dosq_pkg::*;

	dosq_cmd_t  cmd;
	dosq_stat_t st;

	dosq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (s_tuser),
		.st       (st),
		.cmd      (cmd)
	);

	dosq_datapath #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.value         (s_tdata),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.status        (m_tuser),
		.served_number (m_tdata)
	);

endmodule

// ===== rtl/dosq_checker.sv =====
// Port-level checks of the service queue, bound to the top level.
// Depends on dosq_pkg and the defines header.
`include "dual_order_service_queue_unit_defines.svh"

module dosq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import dosq_pkg::*;

	`DOSQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	`DOSQ_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while another is in work")
	`DOSQ_ASSERT_NOW(a_no_number, m_tvalid && (m_tuser == ST_EMPTY || m_tuser == ST_FULL), m_tdata == '0, "number given with empty or full status")

endmodule

bind dual_order_service_queue_unit dosq_checker u_dosq_checker (.*);
